FILE: rtl/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types and codes of the two-table cuckoo hash set.
// ----------------------------------------------------------------------------
package chs_pkg;

	localparam int KEY_BITS   = 31;
	localparam int ROUND_BITS = 6;

	localparam logic [ROUND_BITS-1:0] ROUNDS_RESET = 6'd20;

	typedef logic [KEY_BITS-1:0] key_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_SEARCH = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_INSERTED    = 3'd0,
		ST_DUPLICATE   = 3'd1,
		ST_ROUND_LIMIT = 3'd2,
		ST_FOUND       = 3'd3,
		ST_NOT_FOUND   = 3'd4
	} status_t;

	typedef struct packed {
		opcode_t opcode;
		key_t    key;
	} request_t;

	typedef struct packed {
		status_t status;
		key_t    homeless_key;
	} result_t;

	// one slot of either table
	typedef struct packed {
		logic valid;
		key_t key;
	} entry_t;

endpackage

FILE: rtl/chs_table.sv
// ----------------------------------------------------------------------------
// chs_table
// One table of slots: single write port, single registered read port.
// ----------------------------------------------------------------------------
module chs_table #(
	parameter int ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(ENTRIES)-1:0] waddr,
	input  chs_pkg::entry_t            wdata,
	input  logic                       re,
	input  logic [$clog2(ENTRIES)-1:0] raddr,
	output chs_pkg::entry_t            rdata
);

	chs_pkg::entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/chs_hash.sv
// ----------------------------------------------------------------------------
// chs_hash
// Slot indexes of a key: key mod ENTRIES and (key div ENTRIES) mod ENTRIES.
// ----------------------------------------------------------------------------
module chs_hash #(
	parameter int ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  chs_pkg::key_t              key,
	output logic                       done,
	output logic [$clog2(ENTRIES)-1:0] slot_one,
	output logic [$clog2(ENTRIES)-1:0] slot_two
);

	localparam int IDX_W = $clog2(ENTRIES);

	if ((ENTRIES & (ENTRIES - 1)) == 0) begin : g_pow2
		// power of two: both indexes are plain bit fields of the key
		logic             done_q;
		logic [IDX_W-1:0] one_q;
		logic [IDX_W-1:0] two_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q <= 1'b0;
				one_q  <= '0;
				two_q  <= '0;
			end else begin
				done_q <= start;
				if (start) begin
					one_q <= key[IDX_W-1:0];
					two_q <= key[IDX_W +: IDX_W];
				end
			end
		end

		assign done     = done_q;
		assign slot_one = one_q;
		assign slot_two = two_q;
	end else begin : g_recip
		// divide by the constant ENTRIES with a reciprocal multiply:
		// floor(n / ENTRIES) == (n * RECIP) >> SHIFT for every KEY_BITS-bit n.
		// Remainders lie below ENTRIES, so take them from the low IDX_W bits.
		localparam int SHIFT  = chs_pkg::KEY_BITS + IDX_W;
		localparam int PROD_W = 2 * chs_pkg::KEY_BITS + 1;
		localparam logic [63:0] RECIP_W = ((64'd1 << SHIFT) / 64'(ENTRIES)) + 64'd1;
		localparam logic [chs_pkg::KEY_BITS:0] RECIP = RECIP_W[chs_pkg::KEY_BITS:0];
		localparam logic [IDX_W-1:0] E_LO = IDX_W'(ENTRIES);

		logic                         v_s1;
		logic [chs_pkg::KEY_BITS-1:0] q_s1;
		logic [IDX_W-1:0]             klo_s1;
		logic                         v_s2;
		logic [IDX_W-1:0]             one_s2;
		logic [IDX_W-1:0]             qlo_s2;
		logic [IDX_W-1:0]             qqlo_s2;
		logic                         done_q;
		logic [IDX_W-1:0]             one_q;
		logic [IDX_W-1:0]             two_q;
		logic [PROD_W-1:0]            prod_k;
		logic [PROD_W-1:0]            prod_q;

		always_comb begin
			prod_k = PROD_W'(key) * PROD_W'(RECIP);
			prod_q = PROD_W'(q_s1) * PROD_W'(RECIP);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1    <= 1'b0;
				q_s1    <= '0;
				klo_s1  <= '0;
				v_s2    <= 1'b0;
				one_s2  <= '0;
				qlo_s2  <= '0;
				qqlo_s2 <= '0;
				done_q  <= 1'b0;
				one_q   <= '0;
				two_q   <= '0;
			end else begin
				v_s1   <= start;
				v_s2   <= v_s1;
				done_q <= v_s2;
				if (start) begin
					q_s1   <= chs_pkg::KEY_BITS'(prod_k >> SHIFT);
					klo_s1 <= key[IDX_W-1:0];
				end
				if (v_s1) begin
					one_s2  <= klo_s1 - IDX_W'(q_s1[IDX_W-1:0] * E_LO);
					qlo_s2  <= q_s1[IDX_W-1:0];
					qqlo_s2 <= IDX_W'(prod_q >> SHIFT);
				end
				if (v_s2) begin
					one_q <= one_s2;
					two_q <= qlo_s2 - IDX_W'(qqlo_s2 * E_LO);
				end
			end
		end

		assign done     = done_q;
		assign slot_one = one_q;
		assign slot_two = two_q;
	end

endmodule

FILE: rtl/cuckoo_hash_table.sv
// ----------------------------------------------------------------------------
// cuckoo_hash_table - two-table cuckoo hash set; a search, a duplicate or a zero-round
// insert ends after one hash and one read of both slots; other inserts add eviction rounds
// until a slot is free or at the round limit. Non-power-of-two ENTRIES pipeline the hash.
// One request at a time (busy high); the next is taken at the edge that takes done,
// and the receiver takes done at once and cannot stall.
// Reset empties both tables by a clearing pass over every slot, busy held high.
// ----------------------------------------------------------------------------
module cuckoo_hash_table #(
	parameter int ENTRIES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  chs_pkg::request_t                 request,
	output logic                              done,
	output chs_pkg::result_t                  result,
	input  logic                              cfg_we,
	input  logic [chs_pkg::ROUND_BITS-1:0]    cfg_wdata
);

	localparam int IDX_W = $clog2(ENTRIES);

	// Sequencer. Every probe is a read, a wait for the registered data,
	// then a write back of the new occupant; searches and duplicates only read.
	// A slot that was written is never read again before a hash has run, so the
	// sequencing itself keeps reads behind writes and no forwarding is needed.
	typedef enum logic [2:0] {
		S_CLEAR,   // sweep both tables, marking every slot empty
		S_IDLE,    // wait for a request
		S_HASH0,   // hash of the request key, then read both slots
		S_LOOK,    // compare both slots and decide
		S_PROBE1,  // place key in table one, evict occupant
		S_HASH2,   // hash of the evicted key, then read table two
		S_PROBE2,  // place key in table two, evict occupant
		S_HASH1    // hash of the evicted key, then read table one
	} state_t;

	state_t                          state_q;
	logic [IDX_W-1:0]                clr_q;
	logic [IDX_W-1:0]                a_q;
	logic [IDX_W-1:0]                b_q;
	logic [chs_pkg::ROUND_BITS-1:0]  round_q;
	logic [chs_pkg::ROUND_BITS-1:0]  max_rounds_q;
	chs_pkg::key_t                   k_q;
	chs_pkg::opcode_t                op_q;
	logic                            done_q;
	chs_pkg::result_t                result_q;

	// hash unit
	logic                            h_start;
	chs_pkg::key_t                   h_key;
	logic                            h_done;
	logic [IDX_W-1:0]                h_one;
	logic [IDX_W-1:0]                h_two;

	// table ports
	logic                            we1, we2, re1, re2;
	logic [IDX_W-1:0]                waddr1, waddr2;
	chs_pkg::entry_t                 wdata1, wdata2;
	chs_pkg::entry_t                 rd1, rd2;

	logic                            hit;
	logic                            last_round;

	// ------------------------------------------------------------------------
	// Configuration: eviction round limit; the block does not check it, the user writes it only while idle
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rounds_q <= chs_pkg::ROUNDS_RESET;
		end else if (cfg_we) begin
			max_rounds_q <= cfg_wdata;
		end
	end

	// ------------------------------------------------------------------------
	// Datapath decisions
	// ------------------------------------------------------------------------
	assign hit = (rd1.valid && (rd1.key == k_q)) || (rd2.valid && (rd2.key == k_q));
	// the limit is at least one once evictions have begun
	assign last_round = (round_q == (max_rounds_q - chs_pkg::ROUND_BITS'(1)));

	// Start a hash for a new request, or for the key just evicted
	always_comb begin
		h_start = 1'b0;
		h_key   = request.key;
		case (state_q)
			S_IDLE: begin
				h_start = start;
			end
			S_PROBE1: begin
				h_start = rd1.valid;
				h_key   = rd1.key;
			end
			S_PROBE2: begin
				h_start = rd2.valid && !last_round;
				h_key   = rd2.key;
			end
			default: begin
				h_start = 1'b0;
			end
		endcase
	end

	// Table access control
	always_comb begin
		we1    = 1'b0;
		we2    = 1'b0;
		re1    = 1'b0;
		re2    = 1'b0;
		waddr1 = a_q;
		waddr2 = b_q;
		wdata1 = '{valid: 1'b1, key: k_q};
		wdata2 = '{valid: 1'b1, key: k_q};
		case (state_q)
			S_CLEAR: begin
				we1    = 1'b1;
				we2    = 1'b1;
				waddr1 = clr_q;
				waddr2 = clr_q;
				wdata1 = '0;
				wdata2 = '0;
			end
			S_HASH0: begin
				re1 = h_done;
				re2 = h_done;
			end
			S_PROBE1: begin
				we1 = 1'b1;
			end
			S_HASH2: begin
				re2 = h_done;
			end
			S_PROBE2: begin
				we2 = 1'b1;
			end
			S_HASH1: begin
				re1 = h_done;
			end
			default: begin
				we1 = 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// Sequencer and registered result
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			a_q      <= '0;
			b_q      <= '0;
			round_q  <= '0;
			k_q      <= '0;
			op_q     <= chs_pkg::OP_INSERT;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q    <= request.opcode;
						k_q     <= request.key;
						round_q <= '0;
						state_q <= S_HASH0;
					end
				end
				S_HASH0: begin
					if (h_done) begin
						a_q     <= h_one;
						b_q     <= h_two;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					// read data of slot one stays put for the first probe
					if (op_q == chs_pkg::OP_SEARCH) begin
						done_q   <= 1'b1;
						result_q <= '{status: hit ? chs_pkg::ST_FOUND
						                          : chs_pkg::ST_NOT_FOUND,
						               homeless_key: '0};
						state_q  <= S_IDLE;
					end else if (hit) begin
						done_q   <= 1'b1;
						result_q <= '{status: chs_pkg::ST_DUPLICATE, homeless_key: '0};
						state_q  <= S_IDLE;
					end else if (max_rounds_q == '0) begin
						// no round allowed: drop the new key untouched
						done_q   <= 1'b1;
						result_q <= '{status: chs_pkg::ST_ROUND_LIMIT, homeless_key: k_q};
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_PROBE1;
					end
				end
				S_PROBE1: begin
					if (!rd1.valid) begin
						done_q   <= 1'b1;
						result_q <= '{status: chs_pkg::ST_INSERTED, homeless_key: '0};
						state_q  <= S_IDLE;
					end else begin
						k_q     <= rd1.key;
						state_q <= S_HASH2;
					end
				end
				S_HASH2: begin
					if (h_done) begin
						b_q     <= h_two;
						state_q <= S_PROBE2;
					end
				end
				S_PROBE2: begin
					if (!rd2.valid) begin
						done_q   <= 1'b1;
						result_q <= '{status: chs_pkg::ST_INSERTED, homeless_key: '0};
						state_q  <= S_IDLE;
					end else if (last_round) begin
						// limit reached: the evicted occupant is dropped
						done_q   <= 1'b1;
						result_q <= '{status: chs_pkg::ST_ROUND_LIMIT,
						               homeless_key: rd2.key};
						state_q  <= S_IDLE;
					end else begin
						k_q     <= rd2.key;
						round_q <= round_q + chs_pkg::ROUND_BITS'(1);
						state_q <= S_HASH1;
					end
				end
				S_HASH1: begin
					if (h_done) begin
						a_q     <= h_one;
						state_q <= S_PROBE1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// ------------------------------------------------------------------------
	// Units
	// ------------------------------------------------------------------------
	chs_hash #(
		.ENTRIES (ENTRIES)
	) u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (h_start),
		.key      (h_key),
		.done     (h_done),
		.slot_one (h_one),
		.slot_two (h_two)
	);

	chs_table #(
		.ENTRIES (ENTRIES)
	) u_first (
		.clk   (clk),
		.we    (we1),
		.waddr (waddr1),
		.wdata (wdata1),
		.re    (re1),
		.raddr (h_one),
		.rdata (rd1)
	);

	chs_table #(
		.ENTRIES (ENTRIES)
	) u_second (
		.clk   (clk),
		.we    (we2),
		.waddr (waddr2),
		.wdata (wdata2),
		.re    (re2),
		.raddr (h_two),
		.rdata (rd2)
	);

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a request is still in progress");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_search_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (op_q == chs_pkg::OP_SEARCH)) |->
		((result.status == chs_pkg::ST_FOUND) || (result.status == chs_pkg::ST_NOT_FOUND)))
		else $error("search request gave an insert status");

	a_homeless_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != chs_pkg::ST_ROUND_LIMIT)) |-> (result.homeless_key == '0))
		else $error("homeless key set on a result that dropped nothing");

endmodule

FILE: tb/tb_cuckoo_hash_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cuckoo_hash_table
// Self-checking bench for the two-table cuckoo hash set. A short table of
// directed requests runs first. Six random segments follow, each set to a round
// limit and a rate of sender gaps. Every accepted request goes through a local
// copy of both tables. Each done strobe is checked against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_cuckoo_hash_table;

	localparam int SLOTS       = 16;
	localparam int POOL_SIZE   = 48;
	localparam int SEG_ITEMS   = 322;
	localparam int DRAIN_WAIT  = 300;
	localparam int CYCLE_LIMIT = 3_000_000;

	// one line of the directed table: either a round-limit write or a request
	typedef struct {
		bit                             cfg;
		logic [chs_pkg::ROUND_BITS-1:0] rounds;
		chs_pkg::request_t              req;
		bit                             known;
		chs_pkg::result_t               typed;
	} plan_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	chs_pkg::request_t              request;
	logic                           done;
	chs_pkg::result_t               result;
	logic                           cfg_we;
	logic [chs_pkg::ROUND_BITS-1:0] cfg_wdata;

	// local copy of the hash set and its round limit
	bit                             tab1_vld [SLOTS];
	chs_pkg::key_t                  tab1_key [SLOTS];
	bit                             tab2_vld [SLOTS];
	chs_pkg::key_t                  tab2_key [SLOTS];
	logic [chs_pkg::ROUND_BITS-1:0] limit_rounds = chs_pkg::ROUNDS_RESET;

	chs_pkg::result_t               pending_results [$];
	chs_pkg::key_t                  key_pool [POOL_SIZE];
	bit                             cur_known;
	chs_pkg::result_t               cur_typed;
	int                             errors;
	int                             cycle_count;

	cuckoo_hash_table #(
		.ENTRIES(SLOTS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// -- prediction ----------------------------------------------------------

	function automatic bit key_stored(input chs_pkg::key_t k);
		int a;
		int b;
		a = k % SLOTS;
		b = (k / SLOTS) % SLOTS;
		return (tab1_vld[a] && tab1_key[a] == k) || (tab2_vld[b] && tab2_key[b] == k);
	endfunction

	// Apply one request to the local tables and return what the block must report.
	function automatic chs_pkg::result_t cuckoo_apply(input chs_pkg::request_t req);
		chs_pkg::result_t r;
		chs_pkg::key_t    k;
		chs_pkg::key_t    t;
		int               a;
		int               b;
		int               n;
		bit               placed;
		r.homeless_key = '0;
		if (req.opcode == chs_pkg::OP_SEARCH) begin
			r.status = key_stored(req.key) ? chs_pkg::ST_FOUND : chs_pkg::ST_NOT_FOUND;
		end else if (key_stored(req.key)) begin
			r.status = chs_pkg::ST_DUPLICATE;
		end else begin
			k      = req.key;
			placed = 1'b0;
			// a round limit of zero runs no round and drops the new key
			for (n = 0; n < limit_rounds && !placed; n++) begin
				a = k % SLOTS;
				if (!tab1_vld[a]) begin
					tab1_key[a] = k;
					tab1_vld[a] = 1'b1;
					placed      = 1'b1;
				end else begin
					// kick the occupant of table one over to its slot in table two
					t           = tab1_key[a];
					tab1_key[a] = k;
					k           = t;
					b           = (k / SLOTS) % SLOTS;
					if (!tab2_vld[b]) begin
						tab2_key[b] = k;
						tab2_vld[b] = 1'b1;
						placed      = 1'b1;
					end else begin
						t           = tab2_key[b];
						tab2_key[b] = k;
						k           = t;
					end
				end
			end
			if (placed) begin
				r.status = chs_pkg::ST_INSERTED;
			end else begin
				// evictions stay; whatever key is left in hand is the one dropped
				r.status       = chs_pkg::ST_ROUND_LIMIT;
				r.homeless_key = k;
			end
		end
		return r;
	endfunction

	// -- monitor: check results, predict accepted requests -------------------
	// Sample on the rising edge; all inputs were last changed on a falling edge.
	always @(posedge clk) begin
		chs_pkg::result_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: status %0d homeless_key %0h",
						result.status, result.homeless_key);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						errors++;
					end
					if (result.homeless_key !== want.homeless_key) begin
						$error("homeless_key: expected %0h, got %0h",
							want.homeless_key, result.homeless_key);
						errors++;
					end
				end
			end
			if (cfg_we)
				limit_rounds = cfg_wdata;
			if (start && !busy) begin
				want = cuckoo_apply(request);
				// rows with a typed-in answer are checked against that instead
				if (cur_known)
					want = cur_typed;
				pending_results.push_back(want);
			end
		end
	end

	// -- watchdog ------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// -- driving tasks: entered and left just after a falling edge -----------

	// Present one request and hold it until the block takes it. Start stays
	// high on return, so a following request goes out back to back.
	task automatic send_request(input chs_pkg::request_t rq, input bit known,
			input chs_pkg::result_t typed);
		start     = 1'b1;
		request   = rq;
		cur_known = known;
		cur_typed = typed;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	task automatic idle_cycles(input int n);
		start = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Hold off until every prediction has been met and the block is idle.
	task automatic drain_requests();
		start = 1'b0;
		while (pending_results.size() != 0 || busy)
			@(negedge clk);
	endtask

	task automatic write_rounds(input logic [chs_pkg::ROUND_BITS-1:0] v);
		drain_requests();
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// -- stimulus helpers ----------------------------------------------------

	function automatic plan_row_t plan_req(input chs_pkg::opcode_t op, input chs_pkg::key_t k,
			input bit known = 1'b0,
			input chs_pkg::status_t st = chs_pkg::ST_INSERTED,
			input chs_pkg::key_t hk = '0);
		plan_row_t row;
		row.cfg    = 1'b0;
		row.rounds = '0;
		row.req    = '{opcode: op, key: k};
		row.known  = known;
		row.typed  = '{status: st, homeless_key: hk};
		return row;
	endfunction

	function automatic plan_row_t plan_cfg(input logic [chs_pkg::ROUND_BITS-1:0] v);
		plan_row_t row;
		row        = plan_req(chs_pkg::OP_INSERT, '0);
		row.cfg    = 1'b1;
		row.rounds = v;
		return row;
	endfunction

	// Mostly keys from a small pool so that slots collide, chains of evictions
	// build up and searches hit; the rest are small keys, all ones, zero or fully random.
	function automatic chs_pkg::key_t pick_key();
		int roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return key_pool[$urandom_range(POOL_SIZE-1)];
		else if (roll < 72)
			return chs_pkg::key_t'($urandom_range(511));
		else if (roll < 75)
			return '1;
		else if (roll < 78)
			return '0;
		else
			return chs_pkg::key_t'($urandom);
	endfunction

	// -- main sequence -------------------------------------------------------
	initial begin
		plan_row_t         plan [$];
		int                seg_rounds [6];
		int                seg_idle [6];
		chs_pkg::request_t rq;
		int                s;
		int                i;

		start     = 1'b0;
		request   = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		cur_known = 1'b0;
		cur_typed = '0;
		errors    = 0;
		arst_n    = 1'b0;
		repeat (10) @(negedge clk);
		arst_n    = 1'b1;

		for (i = 0; i < POOL_SIZE; i++) begin
			key_pool[i] = chs_pkg::key_t'($urandom);
			// half the pool shares few second-table slots to force deep chains
			key_pool[i][7:0] = (i % 2) ? 8'($urandom_range(255)) : 8'($urandom_range(63));
		end

		// directed part: empty tables under the reset round limit
		plan.push_back(plan_req(chs_pkg::OP_SEARCH, 31'd0, 1'b1, chs_pkg::ST_NOT_FOUND));
		plan.push_back(plan_req(chs_pkg::OP_INSERT, 31'd0, 1'b1, chs_pkg::ST_INSERTED));
		plan.push_back(plan_req(chs_pkg::OP_INSERT, 31'd0, 1'b1, chs_pkg::ST_DUPLICATE));
		plan.push_back(plan_req(chs_pkg::OP_SEARCH, 31'd0, 1'b1, chs_pkg::ST_FOUND));
		plan.push_back(plan_req(chs_pkg::OP_INSERT, 31'h7FFF_FFFF, 1'b1, chs_pkg::ST_INSERTED));
		plan.push_back(plan_req(chs_pkg::OP_SEARCH, 31'h7FFF_FFFF, 1'b1, chs_pkg::ST_FOUND));
		plan.push_back(plan_req(chs_pkg::OP_SEARCH, 31'h7FFF_FFFE, 1'b1,
			chs_pkg::ST_NOT_FOUND));
		// key 16 shares slot 0 with key 0 and pushes it into table two
		plan.push_back(plan_req(chs_pkg::OP_INSERT, 31'd16));
		plan.push_back(plan_req(chs_pkg::OP_SEARCH, 31'd0));
		plan.push_back(plan_req(chs_pkg::OP_SEARCH, 31'd16));
		// zero rounds: a new key is dropped at once, a duplicate still reported
		plan.push_back(plan_cfg(6'd0));
		plan.push_back(plan_req(chs_pkg::OP_INSERT, 31'd5, 1'b1, chs_pkg::ST_ROUND_LIMIT,
			31'd5));
		plan.push_back(plan_req(chs_pkg::OP_INSERT, 31'h7FFF_FFFF, 1'b1,
			chs_pkg::ST_DUPLICATE));
		plan.push_back(plan_req(chs_pkg::OP_SEARCH, 31'd5, 1'b1, chs_pkg::ST_NOT_FOUND));
		// single round: the last insert drops key 0, stored long before
		plan.push_back(plan_cfg(6'd1));
		plan.push_back(plan_req(chs_pkg::OP_INSERT, 31'd32));
		plan.push_back(plan_req(chs_pkg::OP_INSERT, 31'd512));
		plan.push_back(plan_req(chs_pkg::OP_INSERT, 31'd256));
		plan.push_back(plan_req(chs_pkg::OP_SEARCH, 31'd0));
		// widest limit: long eviction chains through slot 0
		plan.push_back(plan_cfg(6'd63));
		plan.push_back(plan_req(chs_pkg::OP_INSERT, 31'd48));
		plan.push_back(plan_req(chs_pkg::OP_INSERT, 31'd1));
		plan.push_back(plan_req(chs_pkg::OP_INSERT, 31'd768));
		plan.push_back(plan_req(chs_pkg::OP_SEARCH, 31'd256));
		plan.push_back(plan_req(chs_pkg::OP_INSERT, 31'h7FFF_FFF0));
		plan.push_back(plan_cfg(chs_pkg::ROUNDS_RESET));
		plan.push_back(plan_req(chs_pkg::OP_SEARCH, 31'h7FFF_FFFF));

		foreach (plan[i]) begin
			if (plan[i].cfg)
				write_rounds(plan[i].rounds);
			else
				send_request(plan[i].req, plan[i].known, plan[i].typed);
		end

		// random part: a round limit of -1 below means pick one at random
		seg_rounds = '{63, 2, -1, 1, -1, 20};
		seg_idle   = '{30, 30, 57, 57, 0, 0};
		for (s = 0; s < 6; s++) begin
			write_rounds(seg_rounds[s] < 0 ? 6'($urandom_range(1, 63)) : 6'(seg_rounds[s]));
			for (i = 0; i < SEG_ITEMS; i++) begin
				if ($urandom_range(99) < seg_idle[s])
					idle_cycles($urandom_range(1, 6));
				// now and then hold off until the block has answered everything
				if ($urandom_range(149) == 0)
					drain_requests();
				rq.opcode = ($urandom_range(99) < 55) ? chs_pkg::OP_INSERT : chs_pkg::OP_SEARCH;
				rq.key    = pick_key();
				send_request(rq, 1'b0, '0);
			end
		end

		drain_requests();
		repeat (DRAIN_WAIT) @(negedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
